// ----- rtl/nfaec_pkg.sv -----
// Package with the shared types and constants of the epsilon-closure engine.
`default_nettype none

package nfaec_pkg;

  localparam int unsigned MASK_W = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CNT_W  = 5;

  localparam logic [CNT_W-1:0] STATE_COUNT_RESET = 5'd16;

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register index of state_count on the configuration port.
  localparam logic REG_STATE_COUNT = 1'b0;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  state_index;
    logic [MASK_W-1:0] eps_targets;
  } req_t;

  typedef struct packed {
    logic [MASK_W-1:0] closure_mask;
    logic              bad_index;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;
    logic pending;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/nfaec_ctrl.sv -----
// Controller state machine that sequences loads and closure queries.
`default_nettype none

module nfaec_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             req_type_i,
  input  wire nfaec_pkg::status_t status_i,
  output nfaec_pkg::cmd_t       cmd_o,
  output logic                  busy_o
);
  import nfaec_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_type_i == REQ_QUERY) begin
            cmd_o.init = 1'b1;
            state_d    = ST_RUN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_RUN: begin
        // Expand one pending state per cycle until none is left or the index is bad.
        if (status_i.bad || !status_i.pending) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/nfaec_dp.sv -----
// Datapath with the epsilon row table, the closure set and the result register.
`default_nettype none

module nfaec_dp #(
  parameter int NUM_STATES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire nfaec_pkg::cmd_t             cmd_i,
  input  wire nfaec_pkg::req_t             req_i,
  input  wire logic [nfaec_pkg::CNT_W-1:0] state_count_i,
  output nfaec_pkg::status_t               status_o,
  output logic                             done_o,
  output nfaec_pkg::rsp_t                  rsp_o
);
  import nfaec_pkg::*;

  // Only rows below the index range of a request can ever be written or used.
  localparam int Rows    = (NUM_STATES < int'(MASK_W)) ? NUM_STATES : int'(MASK_W);
  localparam int RowIdxW = $clog2(Rows);

  logic [MASK_W-1:0] rows_q [Rows];
  logic [MASK_W-1:0] set_q, set_d;
  logic [MASK_W-1:0] proc_q, proc_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic              bad_q, bad_d;
  logic              done_q;
  rsp_t              rsp_q;

  logic [CNT_W-1:0]  eff_count;
  logic [MASK_W-1:0] pending;
  logic [IDX_W-1:0]  sel;
  logic [MASK_W-1:0] sel_row;

  assign eff_count = (int'(state_count_i) > NUM_STATES) ? CNT_W'(NUM_STATES) : state_count_i;

  always_comb begin
    bad_d  = bad_q;
    mask_d = mask_q;
    set_d  = set_q;
    proc_d = proc_q;
    if (cmd_i.init) begin
      bad_d  = ({1'b0, req_i.state_index} >= eff_count);
      mask_d = (eff_count >= CNT_W'(MASK_W)) ? '1
             : ((MASK_W'(1) << eff_count) - MASK_W'(1));
      set_d  = MASK_W'(1) << req_i.state_index;
      proc_d = '0;
    end else if (cmd_i.step) begin
      set_d       = set_q | (sel_row & mask_q);
      proc_d[sel] = 1'b1;
    end
  end

  // Lowest state that is in the set but not yet expanded.
  assign pending = set_q & ~proc_q;

  always_comb begin
    sel = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel = IDX_W'(i);
      end
    end
  end

  always_comb begin
    sel_row = '0;
    if (int'(sel) < Rows) begin
      sel_row = rows_q[sel[RowIdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Rows; i++) begin
        rows_q[i] <= '0;
      end
    end else if (cmd_i.load && (int'(req_i.state_index) < Rows)) begin
      rows_q[req_i.state_index[RowIdxW-1:0]] <= req_i.eps_targets;
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q  <= bad_d;
    mask_q <= mask_d;
    set_q  <= set_d;
    proc_q <= proc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_q.closure_mask <= bad_q ? '0 : set_q;
      rsp_q.bad_index    <= bad_q;
    end
  end

  assign status_o.bad     = bad_q;
  assign status_o.pending = |pending;
  assign done_o           = done_q;
  assign rsp_o            = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/nfa_epsilon_closure.sv -----
// Top level of the epsilon-closure engine: configuration port, controller and datapath.
`default_nettype none

// A load beat writes its row and gives no result. A query beat with a valid index
// expands one state of its closure per cycle, then strobes the closure on done_o;
// a bad index is strobed with no expansion. Busy stays high while a query runs, and
// no beat is taken until it falls. The receiver cannot stall, so results leave at once.
// Reset clears the epsilon table to no edges and sets state_count to 16.
module nfa_epsilon_closure #(
  parameter int NUM_STATES = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Command channel.
  input  wire logic                         start,
  output logic                              busy,
  input  wire nfaec_pkg::req_t              req_i,
  // Result channel.
  output logic                              done_o,
  output nfaec_pkg::rsp_t                   rsp_o,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import nfaec_pkg::*;

  // The configuration register holds the number of states in use. Its register
  // index is taken from the word address bit; the low byte bits are ignored.
  logic [CNT_W-1:0] state_count_q;
  logic             reg_sel;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q <= STATE_COUNT_RESET;
    end else if (cfg_write && (reg_sel == REG_STATE_COUNT)) begin
      state_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (reg_sel == REG_STATE_COUNT) ? {{(32 - CNT_W){1'b0}}, state_count_q} : '0;

  // The controller only sees the request kind; all payload goes to the datapath.
  cmd_t    cmd;
  status_t status;
  logic    busy_int;

  nfaec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start && !busy_int),
    .req_type_i (req_i.req_type),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_int)
  );

  nfaec_dp #(
    .NUM_STATES (NUM_STATES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_i         (req_i),
    .state_count_i (state_count_q),
    .status_o      (status),
    .done_o        (done_o),
    .rsp_o         (rsp_o)
  );

  assign busy = busy_int;

endmodule

`default_nettype wire

// ----- test/nfaec_closure_check.sv -----
// Checker that predicts epsilon closures from the observed beats and compares the results.
module nfaec_closure_check #(
  parameter int NUM_STATES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   busy,
  input  nfaec_pkg::req_t        req_i,
  input  logic                   done_o,
  input  nfaec_pkg::rsp_t        rsp_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  input  logic                   pready,
  output int                     fail_count,
  output int                     pending,
  output int                     checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import nfaec_pkg::*;

  logic [MASK_W-1:0] eps_rows [NUM_STATES];
  logic [CNT_W-1:0]  state_count;
  rsp_t              expected_closures [$];

  initial begin
    fail_count    = 0;
    checked_count = 0;
    pending       = 0;
  end

  // Rows are kept unmasked; the count mask is applied only when a row is used.
  function automatic rsp_t closure_of(input logic [IDX_W-1:0] idx);
    int unsigned       live;
    logic [MASK_W-1:0] in_use;
    logic [MASK_W-1:0] reach;
    logic [MASK_W-1:0] grown;
    rsp_t              r;
    live = (state_count > NUM_STATES) ? NUM_STATES : state_count;
    r.closure_mask = '0;
    r.bad_index    = 1'b1;
    if (idx >= live) return r;
    in_use = '0;
    for (int s = 0; s < MASK_W; s++) begin
      if (s < live) in_use[s] = 1'b1;
    end
    reach      = '0;
    reach[idx] = 1'b1;
    for (int round = 0; round < NUM_STATES; round++) begin
      grown = reach;
      for (int s = 0; s < NUM_STATES && s < MASK_W; s++) begin
        if (reach[s]) grown = grown | (eps_rows[s] & in_use);
      end
      if (grown == reach) break;
      reach = grown;
    end
    r.closure_mask = reach;
    r.bad_index    = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] closure check: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STATES; s++) eps_rows[s] = '0;
      state_count = STATE_COUNT_RESET;
      expected_closures.delete();
    end else begin
      // A result leaves before a new query in the same cycle can be predicted.
      if (done_o) begin
        if (expected_closures.size() == 0) begin
          report_mismatch("result beat with no query waiting");
        end else begin
          want = expected_closures.pop_front();
          checked_count++;
          if (rsp_o.closure_mask !== want.closure_mask)
            report_mismatch($sformatf("closure_mask got %h, want %h",
                                      rsp_o.closure_mask, want.closure_mask));
          if (rsp_o.bad_index !== want.bad_index)
            report_mismatch($sformatf("bad_index got %b, want %b",
                                      rsp_o.bad_index, want.bad_index));
        end
      end
      if (psel && penable && pwrite && pready && paddr == {REG_STATE_COUNT, 2'b00})
        state_count = pwdata[CNT_W-1:0];
      if (start && !busy) begin
        if (req_i.req_type == REQ_QUERY)
          expected_closures.push_back(closure_of(req_i.state_index));
        else if (req_i.state_index < NUM_STATES)
          eps_rows[req_i.state_index] = req_i.eps_targets;
      end
    end
    pending = expected_closures.size();
  end

endmodule

// ----- test/testbench.sv -----
// Top of the epsilon-closure testbench: clock, reset, beat stimulus and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nfaec_pkg::*;

  localparam int NUM_STATES    = 16;
  // The limit sits well above the slowest correct run: about 1050 beats, each with its
  // busy time and its gap, plus the settle waits around each phase.
  localparam int CYCLE_LIMIT   = 400000;
  // The settle wait outlasts the slowest full closure after its beat is taken.
  localparam int SETTLE        = 20;
  localparam int RANDOM_PHASES = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        done_o;
  rsp_t        rsp_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int checked_count;
  int cycles;
  int loads_sent;
  int queries_sent;
  int settings_used;
  // While burst is set the sender offers beats back to back.
  logic burst;

  nfa_epsilon_closure #(
    .NUM_STATES(NUM_STATES)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  nfaec_closure_check #(
    .NUM_STATES(NUM_STATES)
  ) closure_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .done_o       (done_o),
    .rsp_o        (rsp_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked_count(checked_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: a lost result or a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // All inputs change on the falling edge; the block and the checker sample on the
  // rising edge, so nothing depends on event order within a time step.

  // Waits until the block is free and no closure is owed, then lets the pipeline
  // settle, since a load gives no result that would mark its end.
  task automatic wait_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (busy || pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // An APB write of state_count, with a setup and an access phase, done only while the block is idle.
  task automatic write_state_count(input logic [CNT_W-1:0] value);
    wait_idle();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_STATE_COUNT, 2'b00};
    pwdata  = 32'(value);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    settings_used++;
  endtask

  // Offers one beat and holds it until the rising edge at which busy is low.
  task automatic send_beat(input req_t r);
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (r.req_type == REQ_QUERY) queries_sent++;
    else loads_sent++;
  endtask

  // Gap after a beat: mostly none or short, sometimes long. A zero gap keeps
  // start high so the next beat follows at once.
  task automatic sender_gap();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (burst || roll < 45) len = 0;
    else if (roll < 90) len = $urandom_range(1, 3);
    else len = $urandom_range(8, 40);
    if (len > 0) begin
      @(negedge clk_i);
      start             = 1'b0;
      req_i.req_type    = 1'($urandom);
      req_i.state_index = IDX_W'($urandom);
      req_i.eps_targets = MASK_W'($urandom);
      repeat (len - 1) @(negedge clk_i);
    end
  endtask

  task automatic load_row(input logic [IDX_W-1:0] idx, input logic [MASK_W-1:0] targets);
    req_t r;
    r.req_type    = REQ_LOAD;
    r.state_index = idx;
    r.eps_targets = targets;
    send_beat(r);
    sender_gap();
  endtask

  // The targets field is don't-care on a query, so it carries random bits.
  task automatic ask_closure(input logic [IDX_W-1:0] idx);
    req_t r;
    r.req_type    = REQ_QUERY;
    r.state_index = idx;
    r.eps_targets = MASK_W'($urandom);
    send_beat(r);
    sender_gap();
  endtask

  // Random beats: loads favor sparse rows so that closures form real chains;
  // most queries name a state inside the count, the rest any index.
  task automatic random_beat(input int unsigned live);
    req_t        r;
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      r.req_type    = REQ_LOAD;
      r.state_index = IDX_W'($urandom);
      pick          = $urandom_range(0, 9);
      r.eps_targets = '0;
      if (pick < 5) begin
        r.eps_targets[$urandom_range(0, MASK_W - 1)] = 1'b1;
        if (pick < 2) r.eps_targets[$urandom_range(0, MASK_W - 1)] = 1'b1;
      end else if (pick < 8) begin
        r.eps_targets = MASK_W'($urandom);
      end else if (pick == 9) begin
        r.eps_targets = '1;
      end
    end else begin
      r.req_type = REQ_QUERY;
      if (live == 0 || roll >= 88) r.state_index = IDX_W'($urandom);
      else r.state_index = IDX_W'($urandom_range(0, live - 1));
      r.eps_targets = MASK_W'($urandom);
    end
    send_beat(r);
    sender_gap();
  endtask

  initial begin
    int unsigned count_pick;
    int unsigned live;
    int unsigned items;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cycles        = 0;
    loads_sent    = 0;
    queries_sent  = 0;
    settings_used = 0;
    burst         = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. With the table empty a closure is the state alone.
    write_state_count(CNT_W'(16));
    ask_closure(IDX_W'(0));
    // A row with every bit set reaches the whole automaton in one step.
    load_row(IDX_W'(15), '1);
    ask_closure(IDX_W'(15));
    load_row(IDX_W'(15), '0);
    // A chain 0 -> 1 -> ... -> 15 makes the deepest closure, one state per round.
    for (int s = 0; s < 15; s++) load_row(IDX_W'(s), MASK_W'(1) << (s + 1));
    ask_closure(IDX_W'(0));
    // A count of four cuts the chain off: the mask is applied at query time,
    // an index at the count is a bad index, and a load beyond it is still stored.
    write_state_count(CNT_W'(4));
    ask_closure(IDX_W'(0));
    ask_closure(IDX_W'(4));
    load_row(IDX_W'(9), 16'hABCD);
    // With a count of zero every query is a bad index.
    write_state_count(CNT_W'(0));
    ask_closure(IDX_W'(0));
    // A count above the table size behaves as the table size, and the row
    // stored beyond the old count now takes part in full.
    write_state_count(CNT_W'(31));
    ask_closure(IDX_W'(9));
    ask_closure(IDX_W'(15));
    write_state_count(CNT_W'(1));
    ask_closure(IDX_W'(0));
    ask_closure(IDX_W'(1));

    // Random part: one state_count setting per phase, the extremes first.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: count_pick = 16;
        1: count_pick = 1;
        2: count_pick = 31;
        3: count_pick = 0;
        default: count_pick = $urandom_range(1, 16);
      endcase
      write_state_count(CNT_W'(count_pick));
      live  = (count_pick > NUM_STATES) ? NUM_STATES : count_pick;
      items = (count_pick == 0) ? 40 : 140;
      for (int n = 0; n < items; n++) begin
        if (n % 20 == 0) burst = ($urandom_range(0, 3) == 0);
        // Once in the run the sender holds off until every closure has come back.
        if (phase == 4 && n == items / 2) wait_idle();
        random_beat(live);
      end
    end

    wait_idle();
    $display("covered %0d row loads and %0d closure queries over %0d state_count settings",
             loads_sent, queries_sent, settings_used);
    $display("%0d closure results checked, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/nfaec_pkg.sv
rtl/nfaec_ctrl.sv
rtl/nfaec_dp.sv
rtl/nfa_epsilon_closure.sv
test/nfaec_closure_check.sv
test/testbench.sv
